/* sv/pvfu_pkg.sv */
// Package for the particle velocity force update block.
// Holds the configuration record, register indexes, pipeline stage numbers
// and the control record. No dependencies.
package pvfu_pkg;

  // register bank stage numbers, input side first
  localparam int S_IN       = 0;
  localparam int S_SCALE    = 1;
  localparam int S_SUM      = 2;
  localparam int S_DRAG     = 3;
  localparam int S_ROUND    = 4;
  localparam int S_OUT      = 5;
  localparam int NUM_STAGES = 6;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULE_ENABLE = 4'd0,
    CFG_GRAVITY       = 4'd1,
    CFG_WIND          = 4'd2,
    CFG_DRAG_RATE     = 4'd3,
    CFG_FIELD_ENABLE  = 4'd4,
    CFG_FIELD_ACCEL   = 4'd5,
    CFG_BOX_MIN       = 4'd6,
    CFG_BOX_MAX       = 4'd7
  } cfg_idx_t;

  // gravity reset: y = -9.8 in Q8.8, x = z = 0
  localparam logic [47:0] GRAVITY_RESET = 48'h0000_F633_0000;

  // 1.0 in Q1.24
  localparam logic [24:0] FACTOR_ONE = 25'h100_0000;

  typedef struct packed {
    logic        module_enable;
    logic [47:0] gravity;
    logic [47:0] wind;
    logic [15:0] drag_rate;
    logic        field_enable;
    logic [47:0] field_accel;
    logic [47:0] box_min;
    logic [47:0] box_max;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

/* sv/particle_velocity_force_update.sv */
// Particle velocity force update: Euler step of gravity, wind, drag and box field.
// Accepts one beat per cycle unless in_stall is raised; beats leave in arrival order.
// Six register banks, each at most one multiplier deep; a stall on the output holds
// every full bank and backs up to in_stall only when all six are full.
// Synchronous active-low reset empties the pipe and restores register defaults.
// Depends on pvfu_pkg, pvfu_cfg_regs, pvfu_pipe_ctrl and pvfu_axis_path.
module particle_velocity_force_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              in_vel_x,
  input  logic signed [31:0]              in_vel_y,
  input  logic signed [31:0]              in_vel_z,
  input  logic signed [15:0]              in_pos_x,
  input  logic signed [15:0]              in_pos_y,
  input  logic signed [15:0]              in_pos_z,
  input  logic [15:0]                     in_delta_time,
  input  logic signed [15:0]              in_gravity_scale,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_new_vel_x,
  output logic signed [31:0]              out_new_vel_y,
  output logic signed [31:0]              out_new_vel_z,
  output logic                            out_in_field,
  input  logic                            cfg_wr_en,
  input  logic [pvfu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvfu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int N = pvfu_pkg::NUM_STAGES;

  pvfu_pkg::cfg_t       cfg;
  pvfu_pkg::pipe_ctrl_t ctrl;

  pvfu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  pvfu_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl_o    (ctrl)
  );

  // shared terms: box test and drag factor
  logic signed [15:0] pos [3];
  logic               in_box;
  logic [31:0]        dp;

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  always_comb begin
    in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (pos[a] < $signed(cfg.box_min[16*a +: 16]) ||
          pos[a] > $signed(cfg.box_max[16*a +: 16])) begin
        in_box = 1'b0;
      end
    end
  end

  assign dp = cfg.drag_rate * in_delta_time;

  logic [31:0] dp0_r;
  logic        drag_on0_r;
  logic [24:0] factor1_r;
  logic [24:0] factor2_r;
  logic [N-1:0] hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.load[pvfu_pkg::S_IN]) begin
      dp0_r      <= dp;
      drag_on0_r <= cfg.module_enable && (cfg.drag_rate != '0);
      hit_r[0]   <= cfg.module_enable && cfg.field_enable && in_box;
    end
    if (ctrl.load[pvfu_pkg::S_SCALE]) begin
      // drag off or module off: exact 1.0 keeps the velocity as is
      if (!drag_on0_r) begin
        factor1_r <= pvfu_pkg::FACTOR_ONE;
      end else if (dp0_r >= {7'd0, pvfu_pkg::FACTOR_ONE}) begin
        factor1_r <= '0;
      end else begin
        factor1_r <= pvfu_pkg::FACTOR_ONE - dp0_r[24:0];
      end
    end
    if (ctrl.load[pvfu_pkg::S_SUM]) begin
      factor2_r <= factor1_r;
    end
    for (int k = 1; k < N; k++) begin
      if (ctrl.load[k]) begin
        hit_r[k] <= hit_r[k-1];
      end
    end
  end

  logic signed [31:0] vel_in  [3];
  logic signed [31:0] vel_out [3];

  assign vel_in[0] = in_vel_x;
  assign vel_in[1] = in_vel_y;
  assign vel_in[2] = in_vel_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    pvfu_axis_path u_axis (
      .clk       (clk),
      .ctrl      (ctrl),
      .enable    (cfg.module_enable),
      .vel       (vel_in[a]),
      .dt        (in_delta_time),
      .scale     (in_gravity_scale),
      .grav      ($signed(cfg.gravity[16*a +: 16])),
      .wind      ($signed(cfg.wind[16*a +: 16])),
      .accel     ($signed(cfg.field_accel[16*a +: 16])),
      .factor    (factor2_r),
      .field_hit (hit_r[pvfu_pkg::S_ROUND]),
      .new_vel   (vel_out[a])
    );
  end

  assign out_new_vel_x = vel_out[0];
  assign out_new_vel_y = vel_out[1];
  assign out_new_vel_z = vel_out[2];
  assign out_in_field  = hit_r[pvfu_pkg::S_OUT];

endmodule

/* sv/pvfu_cfg_regs.sv */
// Configuration register file for the particle velocity force update.
// Depends on pvfu_pkg for the register indexes and the cfg_t record.
module pvfu_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [pvfu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pvfu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pvfu_pkg::cfg_t                   cfg_o
);

  pvfu_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.module_enable <= 1'b1;
      cfg_r.gravity       <= pvfu_pkg::GRAVITY_RESET;
      cfg_r.wind          <= '0;
      cfg_r.drag_rate     <= '0;
      cfg_r.field_enable  <= 1'b0;
      cfg_r.field_accel   <= '0;
      cfg_r.box_min       <= '0;
      cfg_r.box_max       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pvfu_pkg::CFG_MODULE_ENABLE: cfg_r.module_enable <= cfg_wdata[0];
        pvfu_pkg::CFG_GRAVITY:       cfg_r.gravity       <= cfg_wdata;
        pvfu_pkg::CFG_WIND:          cfg_r.wind          <= cfg_wdata;
        pvfu_pkg::CFG_DRAG_RATE:     cfg_r.drag_rate     <= cfg_wdata[15:0];
        pvfu_pkg::CFG_FIELD_ENABLE:  cfg_r.field_enable  <= cfg_wdata[0];
        pvfu_pkg::CFG_FIELD_ACCEL:   cfg_r.field_accel   <= cfg_wdata;
        pvfu_pkg::CFG_BOX_MIN:       cfg_r.box_min       <= cfg_wdata;
        pvfu_pkg::CFG_BOX_MAX:       cfg_r.box_max       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* sv/pvfu_pipe_ctrl.sv */
// Pipeline valid bits and stall chain for the force update datapath.
// Depends on pvfu_pkg for the stage count and the pipe_ctrl_t record.
module pvfu_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pvfu_pkg::pipe_ctrl_t ctrl_o
);

  localparam int N = pvfu_pkg::NUM_STAGES;

  logic [N-1:0] valid_r;
  logic [N-1:0] valid_nxt;
  logic [N:0]   rdy;
  logic [N-1:0] feed;

  // a bank takes a new beat when empty or when its own beat moves on
  always_comb begin
    rdy[N] = !out_stall;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign feed = {valid_r[N-2:0], in_valid};

  always_comb begin
    for (int k = 0; k < N; k++) begin
      valid_nxt[k] = rdy[k] ? feed[k] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctrl_o.load = rdy[N-1:0];
  assign in_stall    = !rdy[0];
  assign out_valid   = valid_r[N-1];

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] && !rdy[1] |=> valid_r[0])
    else $error("stalled beat dropped from first bank");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r) && out_stall)
    else $error("input stalled with a bubble in the pipe");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_r[0])
    else $error("accepted beat did not enter first bank");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !valid_r[N-2] |=> !out_valid)
    else $error("output beat repeated");

endmodule

/* sv/pvfu_axis_path.sv */
// One axis of the velocity datapath: gravity, wind, drag and field terms.
// Depends on pvfu_pkg for stage numbers and the pipe_ctrl_t record.
module pvfu_axis_path (
  input  logic                 clk,
  input  pvfu_pkg::pipe_ctrl_t ctrl,
  input  logic                 enable,
  input  logic signed [31:0]   vel,
  input  logic [15:0]          dt,
  input  logic signed [15:0]   scale,
  input  logic signed [15:0]   grav,
  input  logic signed [15:0]   wind,
  input  logic signed [15:0]   accel,
  input  logic [24:0]          factor,
  input  logic                 field_hit,
  output logic signed [31:0]   new_vel
);

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    logic same;
    same = (x[34:31] == 4'b0000) || (x[34:31] == 4'b1111);
    if (same) begin
      return x[31:0];
    end
    return x[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // bank S_IN
  logic signed [31:0] vel0_r;
  logic signed [31:0] gs0_r;
  logic signed [32:0] wp0_r;
  logic signed [32:0] fp0_r;
  logic [15:0]        dt0_r;
  logic signed [31:0] gs;
  logic signed [32:0] wp;
  logic signed [32:0] fp;

  assign gs = grav * scale;
  assign wp = wind * $signed({1'b0, dt});
  assign fp = accel * $signed({1'b0, dt});

  always_ff @(posedge clk) begin
    if (ctrl.load[pvfu_pkg::S_IN]) begin
      vel0_r <= vel;
      gs0_r  <= enable ? gs : '0;
      wp0_r  <= enable ? wp : '0;
      fp0_r  <= fp;
      dt0_r  <= dt;
    end
  end

  // bank S_SCALE
  logic signed [31:0] vel1_r;
  logic signed [48:0] gd1_r;
  logic signed [24:0] wr1_r;
  logic signed [24:0] fr1_r;
  logic signed [48:0] gd;
  logic signed [32:0] wb;
  logic signed [32:0] fb;

  // round to nearest, ties away from zero: bias is half, or half minus one when negative
  assign gd = gs0_r * $signed({1'b0, dt0_r});
  assign wb = wp0_r + $signed({25'd0, ~wp0_r[32], {7{wp0_r[32]}}});
  assign fb = fp0_r + $signed({25'd0, ~fp0_r[32], {7{fp0_r[32]}}});

  always_ff @(posedge clk) begin
    if (ctrl.load[pvfu_pkg::S_SCALE]) begin
      vel1_r <= vel0_r;
      gd1_r  <= gd;
      wr1_r  <= wb[32:8];
      fr1_r  <= fb[32:8];
    end
  end

  // bank S_SUM
  logic signed [31:0] sum2_r;
  logic signed [24:0] fr2_r;
  logic signed [48:0] gb;
  logic signed [34:0] sum;

  assign gb  = gd1_r + $signed({33'd0, ~gd1_r[48], {15{gd1_r[48]}}});
  assign sum = $signed({{3{vel1_r[31]}}, vel1_r}) + $signed({{2{gb[48]}}, gb[48:16]})
             + $signed({{10{wr1_r[24]}}, wr1_r});

  always_ff @(posedge clk) begin
    if (ctrl.load[pvfu_pkg::S_SUM]) begin
      sum2_r <= sat32(sum);
      fr2_r  <= fr1_r;
    end
  end

  // bank S_DRAG
  logic signed [57:0] prod3_r;
  logic signed [24:0] fr3_r;

  always_ff @(posedge clk) begin
    if (ctrl.load[pvfu_pkg::S_DRAG]) begin
      prod3_r <= sum2_r * $signed({1'b0, factor});
      fr3_r   <= fr2_r;
    end
  end

  // bank S_ROUND: factor is at most 1.0, so the rounded value fits 32 bits
  logic signed [31:0] dr4_r;
  logic signed [24:0] fr4_r;
  logic signed [57:0] pb;

  assign pb = prod3_r + $signed({33'd0, ~prod3_r[57], {23{prod3_r[57]}}});

  always_ff @(posedge clk) begin
    if (ctrl.load[pvfu_pkg::S_ROUND]) begin
      dr4_r <= pb[55:24];
      fr4_r <= fr3_r;
    end
  end

  // bank S_OUT
  logic signed [31:0] out5_r;
  logic signed [34:0] fin;

  assign fin = $signed({{3{dr4_r[31]}}, dr4_r})
             + (field_hit ? $signed({{10{fr4_r[24]}}, fr4_r}) : 35'sd0);

  always_ff @(posedge clk) begin
    if (ctrl.load[pvfu_pkg::S_OUT]) begin
      out5_r <= sat32(fin);
    end
  end

  assign new_vel = out5_r;

endmodule

/* dv/particle_velocity_force_update_checker.sv */
// Checker for particle_velocity_force_update: mirrors register writes, predicts the
// updated velocity of each accepted input beat and compares result beats in order.
// Depends on pvfu_pkg.
module particle_velocity_force_update_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic signed [31:0]              in_vel_x,
  input  logic signed [31:0]              in_vel_y,
  input  logic signed [31:0]              in_vel_z,
  input  logic signed [15:0]              in_pos_x,
  input  logic signed [15:0]              in_pos_y,
  input  logic signed [15:0]              in_pos_z,
  input  logic [15:0]                     in_delta_time,
  input  logic signed [15:0]              in_gravity_scale,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [31:0]              out_new_vel_x,
  input  logic signed [31:0]              out_new_vel_y,
  input  logic signed [31:0]              out_new_vel_z,
  input  logic                            out_in_field,
  input  logic                            cfg_wr_en,
  input  logic [pvfu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvfu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_REPORTS      = 10;
  localparam longint      VEL_MAX          = 64'sd2147483647;
  localparam longint      VEL_MIN          = -64'sd2147483648;
  localparam longint      FACTOR_UNITY     = 64'sd16777216;  // 1.0 in Q1.24
  localparam logic [47:0] GRAVITY_AT_RESET = 48'h0000_F633_0000;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               in_field;
  } velocity_t;

  pvfu_pkg::cfg_t regs;
  velocity_t      expected_q[$];
  int             beat_count;

  function automatic longint lane_of(input logic [47:0] vec, input int axis);
    logic signed [15:0] f;
    f = vec[16*axis +: 16];
    return f;
  endfunction

  // nearest, ties away from zero
  function automatic longint round_half_away(input longint x, input int sh);
    longint mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > VEL_MAX) return VEL_MAX;
    if (x < VEL_MIN) return VEL_MIN;
    return x;
  endfunction

  function automatic velocity_t integrate_velocity(input logic [95:0] vel_in,
      input logic [47:0] pos_in, input logic [15:0] step, input logic signed [15:0] gscale,
      input pvfu_pkg::cfg_t c);
    longint             v[3];
    longint             dt, sc, drag, factor;
    logic signed [31:0] w;
    logic               in_box;
    logic               hit;
    velocity_t          r;
    dt = step;
    sc = gscale;
    drag = c.drag_rate;
    in_box = 1'b1;
    hit = 1'b0;
    for (int a = 0; a < 3; a++) begin
      w = vel_in[32*a +: 32];
      v[a] = w;
    end
    if (c.module_enable) begin
      // gravity is Q16.32 before rounding, wind Q8.24; one saturation on the sum
      for (int a = 0; a < 3; a++)
        v[a] = clamp32(v[a] + round_half_away(lane_of(c.gravity, a) * sc * dt, 16)
                       + round_half_away(lane_of(c.wind, a) * dt, 8));
      if (drag != 0) begin
        factor = FACTOR_UNITY - drag * dt;
        if (factor < 0) factor = 0;
        for (int a = 0; a < 3; a++)
          v[a] = round_half_away(v[a] * factor, 24);
      end
      for (int a = 0; a < 3; a++)
        if (lane_of(pos_in, a) < lane_of(c.box_min, a) ||
            lane_of(pos_in, a) > lane_of(c.box_max, a))
          in_box = 1'b0;
      hit = c.field_enable && in_box;
      if (hit)
        for (int a = 0; a < 3; a++)
          v[a] = clamp32(v[a] + round_half_away(lane_of(c.field_accel, a) * dt, 8));
    end
    r.vel_x = v[0][31:0];
    r.vel_y = v[1][31:0];
    r.vel_z = v[2][31:0];
    r.in_field = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    velocity_t got;
    velocity_t want;
    if (!rst_n) begin
      regs = '0;
      regs.module_enable = 1'b1;
      regs.gravity = GRAVITY_AT_RESET;
      expected_q.delete();
      fail_count = 0;
      beat_count = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(integrate_velocity({in_vel_z, in_vel_y, in_vel_x},
            {in_pos_z, in_pos_y, in_pos_x}, in_delta_time, in_gravity_scale, regs));
      if (out_valid && !out_stall) begin
        got.vel_x = out_new_vel_x;
        got.vel_y = out_new_vel_y;
        got.vel_z = out_new_vel_z;
        got.in_field = out_in_field;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result beat %0d with nothing pending: %h %h %h in_field=%b",
                     beat_count, got.vel_x, got.vel_y, got.vel_z, got.in_field);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("result beat %0d: expected %h %h %h %b, got %h %h %h %b",
                       beat_count, want.vel_x, want.vel_y, want.vel_z, want.in_field,
                       got.vel_x, got.vel_y, got.vel_z, got.in_field);
          end
        end
        beat_count++;
      end
      // writes land only while the pipe is empty, so order against the beats is moot
      if (cfg_wr_en)
        case (cfg_index)
          pvfu_pkg::CFG_MODULE_ENABLE: regs.module_enable = cfg_wdata[0];
          pvfu_pkg::CFG_GRAVITY:       regs.gravity = cfg_wdata[47:0];
          pvfu_pkg::CFG_WIND:          regs.wind = cfg_wdata[47:0];
          pvfu_pkg::CFG_DRAG_RATE:     regs.drag_rate = cfg_wdata[15:0];
          pvfu_pkg::CFG_FIELD_ENABLE:  regs.field_enable = cfg_wdata[0];
          pvfu_pkg::CFG_FIELD_ACCEL:   regs.field_accel = cfg_wdata[47:0];
          pvfu_pkg::CFG_BOX_MIN:       regs.box_min = cfg_wdata[47:0];
          pvfu_pkg::CFG_BOX_MAX:       regs.box_max = cfg_wdata[47:0];
          default: ;
        endcase
    end
    outstanding = expected_q.size();
  end

endmodule

/* dv/particle_velocity_force_update_test.sv */
// Top of the particle_velocity_force_update bench: clock, reset, register settings,
// input beats with bursts and gaps, output stalls, and the verdict.
// Depends on pvfu_pkg, the block and particle_velocity_force_update_checker.
module particle_velocity_force_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEMS_PER_PHASE = 228;
  localparam int          NUM_PHASES      = 8;
  localparam int          TAIL_CYCLES     = 24;
  localparam int          CYCLE_LIMIT     = 500000;
  localparam logic [47:0] LANES_MAX       = 48'h7FFF_7FFF_7FFF;
  localparam logic [47:0] LANES_MIN       = 48'h8000_8000_8000;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_SQUARE,
    STALL_LONG
  } stall_mode_t;

  logic                            clk              = 1'b0;
  logic                            rst_n            = 1'b0;
  logic                            in_valid         = 1'b0;
  logic                            in_stall;
  logic signed [31:0]              in_vel_x         = '0;
  logic signed [31:0]              in_vel_y         = '0;
  logic signed [31:0]              in_vel_z         = '0;
  logic signed [15:0]              in_pos_x         = '0;
  logic signed [15:0]              in_pos_y         = '0;
  logic signed [15:0]              in_pos_z         = '0;
  logic [15:0]                     in_delta_time    = '0;
  logic signed [15:0]              in_gravity_scale = '0;
  logic                            out_valid;
  logic                            out_stall        = 1'b0;
  logic signed [31:0]              out_new_vel_x;
  logic signed [31:0]              out_new_vel_y;
  logic signed [31:0]              out_new_vel_z;
  logic                            out_in_field;
  logic                            cfg_wr_en        = 1'b0;
  logic [pvfu_pkg::CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [pvfu_pkg::CFG_DATA_W-1:0] cfg_wdata        = '0;
  int                              fail_count;
  int                              outstanding;
  int                              cycle_count      = 0;
  logic [47:0]                     box_lo           = '0;
  logic [47:0]                     box_hi           = '0;
  stall_mode_t                     stall_mode       = STALL_NONE;
  int                              mode_left        = 0;
  logic [5:0]                      stall_phase      = '0;

  particle_velocity_force_update uut (.*);

  particle_velocity_force_update_checker u_check (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: stall style is redrawn at random each time its hold count runs out
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 4));
      mode_left <= $urandom_range(32, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      STALL_SQUARE: out_stall <= stall_phase[3];
      default:      out_stall <= (stall_phase < 6'd40);
    endcase
  end

  function automatic logic [47:0] random48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [47:0] random_lanes();
    logic [47:0] v;
    for (int a = 0; a < 3; a++)
      case ($urandom_range(0, 5))
        0:       v[16*a +: 16] = 16'h7FFF;
        1:       v[16*a +: 16] = 16'h8000;
        2:       v[16*a +: 16] = 16'h0000;
        default: v[16*a +: 16] = 16'($urandom);
      endcase
    return v;
  endfunction

  task automatic send_particle(input logic [31:0] vx, vy, vz,
                               input logic [15:0] px, py, pz, dt, sc);
    @(negedge clk);
    in_valid <= 1'b1;
    in_vel_x <= vx;
    in_vel_y <= vy;
    in_vel_z <= vz;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_delta_time <= dt;
    in_gravity_scale <= sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pvfu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pvfu_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_settings(input logic enable, field_on, input logic [47:0] grav, wind,
                               input logic [15:0] drag, input logic [47:0] accel, lo, hi);
    drain();
    // junk above the narrow registers' width must be dropped
    write_reg(pvfu_pkg::CFG_MODULE_ENABLE, (random48() & ~48'h1) | 48'(enable));
    write_reg(pvfu_pkg::CFG_GRAVITY, grav);
    write_reg(pvfu_pkg::CFG_WIND, wind);
    write_reg(pvfu_pkg::CFG_DRAG_RATE, {32'($urandom), drag});
    write_reg(pvfu_pkg::CFG_FIELD_ENABLE, (random48() & ~48'h1) | 48'(field_on));
    write_reg(pvfu_pkg::CFG_FIELD_ACCEL, accel);
    write_reg(pvfu_pkg::CFG_BOX_MIN, lo);
    write_reg(pvfu_pkg::CFG_BOX_MAX, hi);
    write_reg(4'(pvfu_pkg::CFG_BOX_MAX) + 4'($urandom_range(1, 8)), random48());
    box_lo = lo;
    box_hi = hi;
  endtask

  task automatic send_random_particle();
    logic [31:0] v[3];
    logic [15:0] q[3];
    logic [15:0] dt;
    logic [15:0] sc;
    int          lo, hi, c;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 9))
        0:       v[a] = 32'h7FFF_FFFF;
        1:       v[a] = 32'h8000_0000;
        2:       v[a] = 32'h7FFF_FFFF - $urandom_range(0, 32'h3FFF_FFFF);
        3:       v[a] = 32'h8000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
        4:       v[a] = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        default: v[a] = $urandom;
      endcase
      lo = $signed(box_lo[16*a +: 16]);
      hi = $signed(box_hi[16*a +: 16]);
      // aim at the box and its edges most of the time
      case ($urandom_range(0, 7))
        0:       c = lo;
        1:       c = hi;
        2:       c = lo - 1;
        3:       c = hi + 1;
        4, 5:    c = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo)) : int'($urandom);
        default: c = $urandom;
      endcase
      q[a] = c[15:0];
    end
    case ($urandom_range(0, 7))
      0:       dt = 16'h0000;
      1:       dt = 16'hFFFF;
      2:       dt = 16'($urandom_range(0, 255));
      default: dt = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       sc = 16'h7FFF;
      1:       sc = 16'h8000;
      2:       sc = 16'h0100;
      default: sc = 16'($urandom);
    endcase
    send_particle(v[0], v[1], v[2], q[0], q[1], q[2], dt, sc);
  endtask

  initial begin
    logic [47:0] lo, hi;
    logic [15:0] drag, a_lo, a_hi;
    int          burst, gap, sent;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: gravity on y only
    send_particle(0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h7FFF);
    send_particle($urandom, $urandom, $urandom, 0, 0, 0, 16'h0000, 16'($urandom));
    send_particle(0, 0, 0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0100);
    send_particle(32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0, 16'h0001, 16'h7FFF);

    // field box of +-0x100 on every axis, light drag: corners and one past them
    load_settings(1'b1, 1'b1, '0, LANES_MAX, 16'h0080, LANES_MIN,
                  48'hFF00_FF00_FF00, 48'h0100_0100_0100);
    send_particle($urandom, $urandom, $urandom, 16'hFF00, 16'hFF00, 16'hFF00,
                  16'h8000, 16'h0100);
    send_particle($urandom, $urandom, $urandom, 16'h0100, 16'h0100, 16'h0100,
                  16'h8000, 16'h0100);
    send_particle($urandom, $urandom, $urandom, 16'h0101, 0, 0, 16'h8000, 16'h0100);
    send_particle($urandom, $urandom, $urandom, 0, 16'hFEFF, 0, 16'h8000, 16'h0100);
    send_particle($urandom, $urandom, $urandom, 0, 0, 0, 16'hFFFF, 16'h0100);

    // full drag: factor clamps at zero for long steps
    load_settings(1'b1, 1'b1, '0, '0, 16'hFFFF, LANES_MAX,
                  48'hFF00_FF00_FF00, 48'h0100_0100_0100);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 16'hFFFF, 0);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 16'h0010, 0);

    // module off: plain pass-through even inside the box
    load_settings(1'b0, 1'b1, LANES_MAX, LANES_MAX, 16'h0100, LANES_MAX,
                  LANES_MIN, LANES_MAX);
    send_particle($urandom, $urandom, $urandom, 0, 0, 0, 16'hFFFF, 16'h7FFF);
    send_particle($urandom, $urandom, $urandom, 0, 0, 0, 16'hFFFF, 16'h8000);

    // box empty on y only
    load_settings(1'b1, 1'b1, '0, '0, '0, LANES_MAX,
                  48'hFF00_0100_FF00, 48'h0100_FF00_0100);
    send_particle($urandom, $urandom, $urandom, 0, 0, 0, 16'hFFFF, 16'h0100);
    send_particle($urandom, $urandom, $urandom, 0, 16'h0100, 0, 16'hFFFF, 16'h0100);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_settings(1'b1, 1'b1, LANES_MAX, LANES_MAX, 16'h0000, LANES_MAX,
                         LANES_MIN, LANES_MAX);
        1: load_settings(1'b1, 1'b1, LANES_MIN, LANES_MIN, 16'hFFFF, LANES_MIN,
                         LANES_MAX, LANES_MIN);
        default: begin
          for (int a = 0; a < 3; a++) begin
            a_lo = 16'($urandom);
            a_hi = 16'($urandom);
            // mostly well-formed boxes; a few stay inverted
            if ($signed(a_lo) > $signed(a_hi) && $urandom_range(0, 5) != 0) begin
              lo[16*a +: 16] = a_hi;
              hi[16*a +: 16] = a_lo;
            end else begin
              lo[16*a +: 16] = a_lo;
              hi[16*a +: 16] = a_hi;
            end
          end
          case ($urandom_range(0, 3))
            0:       drag = 16'h0000;
            1:       drag = 16'hFFFF;
            2:       drag = 16'($urandom_range(1, 1024));
            default: drag = 16'($urandom);
          endcase
          load_settings(p != 3, (p == 5) || ($urandom_range(0, 1) == 1), random_lanes(),
                        random_lanes(), drag, random_lanes(), lo, hi);
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 16);
        gap = (p % 3 == 0) ? 0 : $urandom_range(0, 2 + p);
        for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
          // one full pause mid-run until the pipe has emptied
          if (p == 4 && sent == ITEMS_PER_PHASE / 2) drain();
          send_random_particle();
          sent++;
        end
        hold_off(gap);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
